// File: src/assert_macros.svh
// assertion helpers shared by the rtl
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// same-cycle implication, checked outside reset
`define ASSERT_IMPL(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("assertion failed");

// next-cycle implication, checked outside reset
`define ASSERT_NEXT(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("assertion failed");

`endif

// File: src/dfaesf_pkg.sv
`default_nettype none
package dfaesf_pkg;
    localparam int DEF_MAX_STATES  = 16;
    localparam int DEF_MAX_SYMBOLS = 4;
    localparam int STATE_W         = 4;
    localparam int MASK_W          = 16;
    localparam int COUNT_W         = 5;

    // control broadcast from the sequencer to every cell
    typedef struct packed {
        logic               init;
        logic               shift;
        logic               set;
        logic [STATE_W-1:0] set_row;
        logic [STATE_W-1:0] set_col;
        logic               acc_we;
        logic [STATE_W-1:0] acc_row;
        logic               acc_val;
    } t_cell_ctl;
endpackage
`default_nettype wire

// File: src/dfaesf_in_if.sv
`default_nettype none
interface dfaesf_in_if;
    logic       valid;
    logic       ready;
    logic [3:0] from_state;
    logic [1:0] symbol;
    logic [3:0] to_state;
    logic       accepting;
    logic       last;

    modport source (output valid, from_state, symbol, to_state, accepting, last,
                    input ready);
    modport sink (input valid, from_state, symbol, to_state, accepting, last,
                  output ready);
endinterface
`default_nettype wire

// File: src/dfaesf_out_if.sv
`default_nettype none
interface dfaesf_out_if;
    logic        valid;
    logic        ready;
    logic [3:0]  state_index;
    logic [15:0] equivalent_mask;
    logic        bad_target;
    logic        last_result;

    modport source (output valid, state_index, equivalent_mask, bad_target, last_result,
                    input ready);
    modport sink (input valid, state_index, equivalent_mask, bad_target, last_result,
                  output ready);
endinterface
`default_nettype wire

// File: src/dfaesf_cell.sv
`default_nettype none
module dfaesf_cell #(
    parameter int LIM = 16,
    parameter int IDX = 0
) (
    input  wire logic                  i_clk,
    input  wire logic                  i_rst_n,
    input  wire dfaesf_pkg::t_cell_ctl i_ctl,
    input  wire logic [LIM-1:0]        i_acc_vec,
    input  wire logic [LIM-1:0]        i_next_row,
    output logic [LIM-1:0]             o_row,
    output logic                       o_acc
);
    localparam int IW = $clog2(LIM);

    logic [LIM-1:0] r_row;
    logic           r_acc;
    logic [LIM-1:0] n_init_row;

    // pairs with a lower state that differ in acceptance
    always_comb begin
        for (int j = 0; j < LIM; j++) begin
            n_init_row[j] = (j < IDX) && (i_acc_vec[j] != r_acc);
        end
    end

    // accepting flag of this state
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_acc <= 1'b0;
        end else if (i_ctl.acc_we && i_ctl.acc_row == dfaesf_pkg::STATE_W'(IDX)) begin
            r_acc <= i_ctl.acc_val;
        end
    end

    // distinguishability row: init, mark, or shift toward the output end
    always_ff @(posedge i_clk) begin
        if (i_ctl.init) begin
            r_row <= n_init_row;
        end else if (i_ctl.shift) begin
            r_row <= i_next_row;
        end else if (i_ctl.set && i_ctl.set_row == dfaesf_pkg::STATE_W'(IDX)) begin
            r_row[i_ctl.set_col[IW-1:0]] <= 1'b1;
        end
    end

    assign o_row = r_row;
    assign o_acc = r_acc;
endmodule
`default_nettype wire

// File: src/dfa_equivalent_state_finder.sv
// DFA equivalent-state finder, table-filling minimization.
// Input channel i_in: one transaction per transition entry (from_state, symbol,
// to_state, accepting of the source). Entries load one per cycle while idle.
// A transaction with last set loads its entry and starts minimization; ready is
// low until every result of that run has been handed to the output register.
// Config port: i_cfg_we / i_cfg_index / i_cfg_data, 0 = state_count,
// 1 = symbol_count, written while idle.
// One cell per state holds its acceptance and its row of distinguishable marks.
// Each marking pass walks all pairs and symbols in use; each (pair, symbol)
// step reads both targets from the single transition memory in S_RD, whose
// two reads are registered, and checks the target pair in S_CHK; passes
// repeat until none marks. Start passes through the S_INIT setup state, then
// the marking passes run and n results follow.
// Results leave on o_out in state order, one per cycle, as the cell chain
// shifts its rows toward the output; a stalled receiver holds the output
// register and the chain. Reset clears acceptance, the error flag and control
// state; the transition memory is undefined until written.
`default_nettype none
`include "assert_macros.svh"
module dfa_equivalent_state_finder #(
    parameter int MAX_STATES  = dfaesf_pkg::DEF_MAX_STATES,
    parameter int MAX_SYMBOLS = dfaesf_pkg::DEF_MAX_SYMBOLS
) (
    input  wire logic       i_clk,
    input  wire logic       i_rst_n,
    input  wire logic       i_cfg_we,
    input  wire logic       i_cfg_index,
    input  wire logic [4:0] i_cfg_data,
    dfaesf_in_if.sink       i_in,
    dfaesf_out_if.source    o_out
);
    localparam int LIM   = (MAX_STATES < 16) ? MAX_STATES : 16;
    localparam int IW    = $clog2(LIM);
    localparam int SYW   = (MAX_SYMBOLS > 1) ? $clog2(MAX_SYMBOLS) : 1;
    localparam int DEPTH = LIM * MAX_SYMBOLS;
    localparam int AW    = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int CW    = dfaesf_pkg::COUNT_W;
    localparam int SW    = dfaesf_pkg::STATE_W;

    localparam logic [0:0] CFG_STATES  = 1'b0;
    localparam logic [0:0] CFG_SYMBOLS = 1'b1;

    localparam logic [2:0] S_IDLE = 3'd0;
    localparam logic [2:0] S_INIT = 3'd1;
    localparam logic [2:0] S_RD   = 3'd2;
    localparam logic [2:0] S_CHK  = 3'd3;
    localparam logic [2:0] S_EMIT = 3'd4;

    logic [CW-1:0]  r_sc, r_syc, r_n, r_syms, n_cur, n_syms;
    logic [2:0]     r_state;
    logic [SW-1:0]  r_i, r_j;
    logic [SYW-1:0] r_s;
    logic           r_chg, r_err, r_bad;
    logic [SW-1:0]  r_rd_a, r_rd_b;
    logic [SW-1:0]  mem [DEPTH];
    logic           r_ov, r_olast, r_obad;
    logic [SW-1:0]  r_oidx;
    logic [dfaesf_pkg::MASK_W-1:0] r_omask;

    logic           in_acc, load_ok, hit, already, emit_go, out_last, pass_end;
    logic [SW-1:0]  hi, lo;
    logic [AW-1:0]  wr_addr, rd_addr_a, rd_addr_b;
    logic [LIM-1:0] below, acc_vec;
    logic [LIM-1:0] rows [LIM];
    dfaesf_pkg::t_cell_ctl ctl;

    // configuration registers
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_sc  <= CW'(2);
            r_syc <= CW'(2);
        end else if (i_cfg_we) begin
            case (i_cfg_index)
                CFG_STATES:  r_sc  <= i_cfg_data;
                CFG_SYMBOLS: r_syc <= {2'b00, i_cfg_data[2:0]};
                default: ;
            endcase
        end
    end

    // saturated counts in use
    always_comb begin
        n_cur  = (r_sc == '0) ? CW'(1) : ((r_sc > CW'(LIM)) ? CW'(LIM) : r_sc);
        n_syms = (r_syc == '0) ? CW'(1)
                 : ((r_syc > CW'(MAX_SYMBOLS)) ? CW'(MAX_SYMBOLS) : r_syc);
    end

    assign i_in.ready = (r_state == S_IDLE);
    assign in_acc     = i_in.valid && i_in.ready;
    assign load_ok    = in_acc && ({1'b0, i_in.from_state} < CW'(LIM))
                        && ({3'b000, i_in.symbol} < CW'(MAX_SYMBOLS));

    // memory addresses
    assign wr_addr   = AW'(AW'(i_in.from_state) * AW'(MAX_SYMBOLS) + AW'(i_in.symbol));
    assign rd_addr_a = AW'(AW'(r_i) * AW'(MAX_SYMBOLS) + AW'(r_s));
    assign rd_addr_b = AW'(AW'(r_j) * AW'(MAX_SYMBOLS) + AW'(r_s));

    // transition memory, one write and two registered reads
    always_ff @(posedge i_clk) begin
        if (load_ok) begin
            mem[wr_addr] <= i_in.to_state;
        end
        r_rd_a <= mem[rd_addr_a];
        r_rd_b <= mem[rd_addr_b];
    end

    // target pair lookup in the cell rows
    always_comb begin
        hi      = (r_rd_a > r_rd_b) ? r_rd_a : r_rd_b;
        lo      = (r_rd_a > r_rd_b) ? r_rd_b : r_rd_a;
        hit     = (r_rd_a != r_rd_b) && ({1'b0, hi} < r_n)
                  && rows[hi[IW-1:0]][lo[IW-1:0]];
        already = rows[r_i[IW-1:0]][r_j[IW-1:0]];
    end

    // last symbol of the last pair in a pass
    assign pass_end = ((CW'(r_s) + CW'(1)) >= r_syms) && ((r_j + SW'(1)) >= r_i)
                      && (({1'b0, r_i} + CW'(1)) >= r_n);

    assign emit_go  = (r_state == S_EMIT) && (!r_ov || o_out.ready);
    assign out_last = ({1'b0, r_i} + CW'(1)) == r_n;

    // cell control
    always_comb begin
        ctl         = '0;
        ctl.init    = (r_state == S_INIT);
        ctl.shift   = emit_go;
        ctl.set     = (r_state == S_CHK) && hit && !already;
        ctl.set_row = r_i;
        ctl.set_col = r_j;
        ctl.acc_we  = load_ok;
        ctl.acc_row = i_in.from_state;
        ctl.acc_val = i_in.accepting;
    end

    // chain of cells, row k hands to row k-1 while results drain
    for (genvar k = 0; k < LIM; k++) begin : g_cell
        logic [LIM-1:0] w_next;
        if (k == LIM - 1) begin : g_end
            assign w_next = '0;
        end else begin : g_mid
            assign w_next = rows[k+1];
        end
        dfaesf_cell #(.LIM(LIM), .IDX(k)) u_cell (
            .i_clk      (i_clk),
            .i_rst_n    (i_rst_n),
            .i_ctl      (ctl),
            .i_acc_vec  (acc_vec),
            .i_next_row (w_next),
            .o_row      (rows[k]),
            .o_acc      (acc_vec[k])
        );
    end

    // lower-state mask for the result
    always_comb begin
        for (int b = 0; b < LIM; b++) begin
            below[b] = (SW'(b) < r_i);
        end
    end

    // sequencer
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
            r_err   <= 1'b0;
            r_bad   <= 1'b0;
            r_chg   <= 1'b0;
            r_i     <= '0;
            r_j     <= '0;
            r_s     <= '0;
            r_n     <= CW'(2);
            r_syms  <= CW'(2);
        end else begin
            case (r_state)
                S_IDLE: begin
                    if (in_acc) begin
                        if (i_in.last) begin
                            r_bad   <= r_err || ({1'b0, i_in.to_state} >= n_cur);
                            r_err   <= 1'b0;
                            r_n     <= n_cur;
                            r_syms  <= n_syms;
                            r_state <= S_INIT;
                        end else if ({1'b0, i_in.to_state} >= n_cur) begin
                            r_err <= 1'b1;
                        end
                    end
                end
                S_INIT: begin
                    r_chg <= 1'b0;
                    r_s   <= '0;
                    r_j   <= '0;
                    if (r_n < CW'(2)) begin
                        r_i     <= '0;
                        r_state <= S_EMIT;
                    end else begin
                        r_i     <= SW'(1);
                        r_state <= S_RD;
                    end
                end
                S_RD: begin
                    r_state <= S_CHK;
                end
                S_CHK: begin
                    r_state <= S_RD;
                    if (pass_end) begin
                        r_chg <= 1'b0;
                    end else if (hit && !already) begin
                        r_chg <= 1'b1;
                    end
                    if ((CW'(r_s) + CW'(1)) < r_syms) begin
                        r_s <= r_s + SYW'(1);
                    end else begin
                        r_s <= '0;
                        if ((r_j + SW'(1)) < r_i) begin
                            r_j <= r_j + SW'(1);
                        end else begin
                            r_j <= '0;
                            if (({1'b0, r_i} + CW'(1)) < r_n) begin
                                r_i <= r_i + SW'(1);
                            end else if (r_chg || (hit && !already)) begin
                                r_i <= SW'(1);
                            end else begin
                                r_i     <= '0;
                                r_state <= S_EMIT;
                            end
                        end
                    end
                end
                S_EMIT: begin
                    if (emit_go) begin
                        if (out_last) begin
                            r_state <= S_IDLE;
                        end else begin
                            r_i <= r_i + SW'(1);
                        end
                    end
                end
                default: r_state <= S_IDLE;
            endcase
        end
    end

    // output register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_ov <= 1'b0;
        end else if (emit_go) begin
            r_ov <= 1'b1;
        end else if (o_out.ready) begin
            r_ov <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (emit_go) begin
            r_oidx  <= r_i;
            r_omask <= dfaesf_pkg::MASK_W'(~rows[0] & below);
            r_obad  <= r_bad;
            r_olast <= out_last;
        end
    end

    assign o_out.valid           = r_ov;
    assign o_out.state_index     = r_oidx;
    assign o_out.equivalent_mask = r_omask;
    assign o_out.bad_target      = r_obad;
    assign o_out.last_result     = r_olast;

    `ASSERT_NEXT(a_start_init, i_clk, i_rst_n, in_acc && i_in.last, r_state == S_INIT)
    `ASSERT_IMPL(a_pair_order, i_clk, i_rst_n, r_state == S_CHK, r_j < r_i)
    `ASSERT_IMPL(a_row_in_use, i_clk, i_rst_n, r_state == S_CHK, {1'b0, r_i} < r_n)
    `ASSERT_IMPL(a_no_load_busy, i_clk, i_rst_n, r_state != S_IDLE, !i_in.ready)
endmodule
`default_nettype wire
